/* rtl/swtg_pkg.sv */
// ----------------------------------------------------------------------------
// swtg_pkg
// Shared widths, codes and controller/datapath handshake structs for the
// square wave tone generator.
// ----------------------------------------------------------------------------
package swtg_pkg;

  localparam int TPM_W     = 20;  // ticks_per_ms
  localparam int AMIN_W    = 16;  // audible_min_hz
  localparam int FREQ_W    = 16;
  localparam int DUR_W     = 16;
  localparam int PERIOD_W  = 30;
  localparam int PHASE_W   = 29;
  localparam int ELAPSED_W = 37;
  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = TPM_W;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIBLE_MIN_HZ = 1'd1;

  // input item kinds carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_NOTE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_note;    // latch note fields from the input item
    logic load_mul;     // register target and divider numerator
    logic div_step;     // one restoring divider step
    logic tick_step;    // advance time by one tick
    logic note_commit;  // start the latched note (rest or tone)
    logic out_load;     // load the result register
  } swtg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode_idle;
    logic is_rest;
    logic div_last;
  } swtg_sts_t;

endpackage

/* rtl/swtg_ctrl.sv */
// ----------------------------------------------------------------------------
// swtg_ctrl
// Sequencer: input/output handshakes and the note setup sequence
// (multiply, select, divide, emit).
// ----------------------------------------------------------------------------
module swtg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  swtg_pkg::swtg_sts_t sts,
  output swtg_pkg::swtg_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_RUN  = 5'b00001,
    S_MUL  = 5'b00010,
    S_SEL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_fire;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_RUN) && out_free;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_RUN: begin
        if (in_fire) begin
          if (in_op == swtg_pkg::OP_NOTE && sts.mode_idle) begin
            cmd.load_note = 1'b1;
            state_nxt     = S_MUL;
          end else begin
            cmd.tick_step = (in_op == swtg_pkg::OP_TICK);
            cmd.out_load  = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.load_mul = 1'b1;
        state_nxt    = S_SEL;
      end
      S_SEL: begin
        state_nxt = sts.is_rest ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.note_commit = 1'b1;
          cmd.out_load    = 1'b1;
          state_nxt       = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/swtg_dp.sv */
// ----------------------------------------------------------------------------
// swtg_dp
// Datapath: configuration registers, note setup multipliers, restoring
// period divider, tone/rest timing state and the result register.
// ----------------------------------------------------------------------------
module swtg_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [swtg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swtg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [swtg_pkg::FREQ_W-1:0]          in_freq,
  input  logic [swtg_pkg::DUR_W-1:0]           in_dur,
  input  swtg_pkg::swtg_cmd_t                  cmd,
  output swtg_pkg::swtg_sts_t                  sts,
  output logic [3:0]                           out_res
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_REST = 3'b010,
    MODE_TONE = 3'b100
  } mode_t;

  // configuration
  logic [swtg_pkg::TPM_W-1:0]  tpm_r;
  logic [swtg_pkg::AMIN_W-1:0] amin_r;

  // latched note and setup
  logic [swtg_pkg::FREQ_W-1:0]    freq_r;
  logic [swtg_pkg::DUR_W-1:0]     dur_r;
  logic                           is_rest_r;
  logic [swtg_pkg::PERIOD_W-1:0]  quo_r, quo_nxt;
  logic [swtg_pkg::FREQ_W-1:0]    rem_r, rem_nxt;
  logic [swtg_pkg::DIVCNT_W-1:0]  div_cnt_r;

  // timing state
  mode_t                           mode_r, mode_nxt;
  logic                            pin_r, pin_nxt;
  logic                            high_r, high_nxt;
  logic [swtg_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [swtg_pkg::PHASE_W-1:0]    phase_r, phase_nxt;
  logic [swtg_pkg::ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [swtg_pkg::ELAPSED_W-1:0]  target_r;

  logic [3:0] out_r;

  logic [swtg_pkg::DUR_W+swtg_pkg::TPM_W-1:0] tgt_prod;
  logic [swtg_pkg::PERIOD_W-1:0]              num_prod;
  logic [swtg_pkg::FREQ_W:0]                  div_sh;
  logic                                       div_ge;
  logic [swtg_pkg::PHASE_W-1:0]               half;
  logic [swtg_pkg::PHASE_W-1:0]               phase_inc;
  logic [swtg_pkg::PERIOD_W-1:0]              period_add;
  logic [swtg_pkg::ELAPSED_W-1:0]             el_rest, el_tone;
  logic                                       acc, fin;

  assign tgt_prod = {{swtg_pkg::TPM_W{1'b0}}, dur_r} * {{swtg_pkg::DUR_W{1'b0}}, tpm_r};
  assign num_prod = swtg_pkg::PERIOD_W'(tpm_r) * swtg_pkg::PERIOD_W'(swtg_pkg::MS_PER_S);

  // restoring divider, one quotient bit per step
  assign div_sh  = {rem_r, quo_r[swtg_pkg::PERIOD_W-1]};
  assign div_ge  = div_sh >= {1'b0, freq_r};
  assign rem_nxt = div_ge ? swtg_pkg::FREQ_W'(div_sh - {1'b0, freq_r})
                          : div_sh[swtg_pkg::FREQ_W-1:0];
  assign quo_nxt = {quo_r[swtg_pkg::PERIOD_W-2:0], div_ge};

  // half period, at least one tick
  assign half = (period_r[swtg_pkg::PERIOD_W-1:1] == '0) ? swtg_pkg::PHASE_W'(1)
                                                         : period_r[swtg_pkg::PERIOD_W-1:1];
  assign phase_inc  = phase_r + swtg_pkg::PHASE_W'(1);
  assign period_add = (period_r == '0) ? swtg_pkg::PERIOD_W'(1) : period_r;
  assign el_rest    = elapsed_r + swtg_pkg::ELAPSED_W'(1);
  assign el_tone    = elapsed_r + swtg_pkg::ELAPSED_W'(period_add);

  always_comb begin
    mode_nxt    = mode_r;
    pin_nxt     = pin_r;
    high_nxt    = high_r;
    period_nxt  = period_r;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    acc         = 1'b0;
    fin         = 1'b0;
    if (cmd.note_commit) begin
      acc         = 1'b1;
      elapsed_nxt = '0;
      phase_nxt   = '0;
      high_nxt    = 1'b0;
      if (is_rest_r) begin
        period_nxt = '0;
        if (target_r == '0) begin
          fin = 1'b1;
        end else begin
          mode_nxt = MODE_REST;
        end
      end else begin
        period_nxt = quo_r;
        pin_nxt    = 1'b0;
        mode_nxt   = MODE_TONE;
      end
    end else if (cmd.tick_step) begin
      case (mode_r)
        MODE_REST: begin
          elapsed_nxt = el_rest;
          if (el_rest >= target_r) begin
            mode_nxt = MODE_IDLE;
            fin      = 1'b1;
          end
        end
        MODE_TONE: begin
          if (phase_inc >= half) begin
            phase_nxt = '0;
            if (!high_r) begin
              high_nxt = 1'b1;
              pin_nxt  = 1'b1;
            end else begin
              elapsed_nxt = el_tone;
              if (el_tone > target_r) begin
                mode_nxt = MODE_IDLE;
                pin_nxt  = 1'b1;
                fin      = 1'b1;
              end else begin
                high_nxt = 1'b0;
                pin_nxt  = 1'b0;
              end
            end
          end else begin
            phase_nxt = phase_inc;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r     <= swtg_pkg::TPM_W'(1000);
      amin_r    <= swtg_pkg::AMIN_W'(20);
      mode_r    <= MODE_IDLE;
      pin_r     <= 1'b0;
      high_r    <= 1'b0;
      period_r  <= '0;
      phase_r   <= '0;
      elapsed_r <= '0;
      target_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swtg_pkg::REG_TICKS_PER_MS:   tpm_r  <= cfg_wdata;
          swtg_pkg::REG_AUDIBLE_MIN_HZ: amin_r <= cfg_wdata[swtg_pkg::AMIN_W-1:0];
          default: ;
        endcase
      end
      mode_r    <= mode_nxt;
      pin_r     <= pin_nxt;
      high_r    <= high_nxt;
      period_r  <= period_nxt;
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      if (cmd.load_mul) begin
        target_r <= swtg_pkg::ELAPSED_W'(tgt_prod);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_note) begin
      freq_r <= in_freq;
      dur_r  <= in_dur;
    end
    if (cmd.load_mul) begin
      is_rest_r <= (freq_r == '0) || (freq_r < amin_r);
      quo_r     <= num_prod;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= quo_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + swtg_pkg::DIVCNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r <= {fin, acc, (mode_nxt != MODE_IDLE), pin_nxt};
    end
  end

  assign sts.mode_idle = (mode_r == MODE_IDLE);
  assign sts.is_rest   = is_rest_r;
  assign sts.div_last  = (div_cnt_r == swtg_pkg::DIVCNT_W'(swtg_pkg::DIV_STEPS - 1));
  assign out_res       = out_r;

  a_phase_below_half: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_TONE) |-> (phase_r < half))
    else $error("tone phase reached half period");

  a_elapsed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (elapsed_r <= target_r))
    else $error("elapsed ticks beyond target while busy");

  a_fin_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && fin) |=> (mode_r == MODE_IDLE))
    else $error("finished item left block busy");

  a_tone_ends_high: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick_step && fin && (mode_r == MODE_TONE)) |=> pin_r)
    else $error("tone ended with pin low");

endmodule

/* rtl/square_wave_tone_generator.sv */
// ----------------------------------------------------------------------------
// square_wave_tone_generator
// Buzzer tone generator: square wave notes and rests timed by tick items.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. Tick items, and note items
// that arrive while a tone or rest is still playing, need no setup steps and
// can follow back to back while the output is not stalled. A note taken while
// idle occupies the block until its result is delivered: it steps through the
// duration and numerator multiplies, a select step, 30 steps of the bit-serial
// period divider (tones only) and a final step that delivers the result.
// Configuration writes take effect at the next clock edge.
module square_wave_tone_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [swtg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swtg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [swtg_pkg::IN_DATA_W-1:0]        in_tdata,   // frequency_hz, duration_ms
  input  logic                                  in_tuser,   // op
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [swtg_pkg::OUT_DATA_W-1:0]       out_tdata   // pin_level, busy_res,
                                                            // accepted, finished, zeros
);

  swtg_pkg::swtg_cmd_t cmd;
  swtg_pkg::swtg_sts_t sts;
  logic [3:0]          res;

  swtg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swtg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_freq   (in_tdata[swtg_pkg::FREQ_W-1:0]),
    .in_dur    (in_tdata[swtg_pkg::FREQ_W+swtg_pkg::DUR_W-1:swtg_pkg::FREQ_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_res   (res)
  );

  assign out_tdata = {{(swtg_pkg::OUT_DATA_W-4){1'b0}}, res};

endmodule
